### rtl/mhtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pkg: shared types and constants of the min-heap timeout queue
// Sizes, command and status codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mhtq_pkg;

    localparam int CAPACITY  = 32;
    localparam int ID_LIMIT  = 1024;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CHILD_W   = IDX_W + 2;
    localparam int ID_W      = $clog2(ID_LIMIT);
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 20;
    localparam int WAIT_W    = 20;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIRE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_POS_READ,
        OP_SLOT_READ,
        OP_CLEAR,
        OP_ADD_KNOWN,
        OP_ADD_NEW,
        OP_TICK_READ,
        OP_REMOVE,
        OP_LOAD_LAST,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ_L,
        OP_DN_LATCH_L,
        OP_DN_PICK_R,
        OP_DN_MOVE,
        OP_PLACE
    } dp_op_t;

    // Source of the queue_empty flag of an emitted result.
    typedef enum logic [1:0] {
        QE_NOW,
        QE_ONE,
        QE_ZERO
    } qe_sel_t;

    typedef struct packed {
        logic    en;
        logic    fired;
        status_t status;
        logic    with_wait;
        qe_sel_t qe;
        logic    last;
    } emit_t;

    typedef struct packed {
        dp_op_t op;
        emit_t  emit;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic known;
        logic full;
        logic count_zero;
        logic i_zero;
        logic i_is_last;
        logic has_left;
        logic has_right;
        logic up_earlier;
        logic right_earlier;
        logic down_earlier;
        logic root_expired;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SLOT_RD,
        ST_DECIDE,
        ST_CLEAR,
        ST_EMIT_CLEAR,
        ST_TICK,
        ST_TICK_CMP,
        ST_REMOVE,
        ST_REMOVE_LOAD,
        ST_UP,
        ST_UP_CMP,
        ST_DN,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_PLACE
    } state_t;

    // Wrap-aware time order: a comes before b when a - b is negative.
    function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

### rtl/min_heap_timeout_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_timeout_queue: timer queue on a binary min-heap
// Add or restart, fire, tick and clear commands over up to CAPACITY timers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_ready   cmd, timer_id, timeout_ms, now_ms
//  out       from block out_valid / out_ready expired_id, fired, status,
//                                             next_wait_ms, queue_empty, last
//
// One request at a time. An add or a removal takes steps for each level moved
// up or down, paced by the single read port of the heap memory. A tick emits
// and removes one expired timer after another until the root is not expired
// or the queue is empty.
// Reset empties the queue at once; no sweep is needed.
// A stalled result holds the sequencer only when a new result is due.
// ----------------------------------------------------------------------------
module min_heap_timeout_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [mhtq_pkg::ID_W-1:0]         timer_id,
    input  logic [mhtq_pkg::TIMEOUT_W-1:0]    timeout_ms,
    input  logic [mhtq_pkg::TIME_W-1:0]       now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mhtq_pkg::ID_W-1:0]         expired_id,
    output logic                              fired,
    output logic [1:0]                        status,
    output logic [mhtq_pkg::WAIT_W-1:0]       next_wait_ms,
    output logic                              queue_empty,
    output logic                              last
);
    import mhtq_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t sts;

    // Sequencer.
    mhtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Storage and result register.
    mhtq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .timer_id     (timer_id),
        .timeout_ms   (timeout_ms),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .expired_id   (expired_id),
        .fired        (fired),
        .status       (status),
        .next_wait_ms (next_wait_ms),
        .queue_empty  (queue_empty),
        .last         (last)
    );

endmodule

### rtl/mhtq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_dp: heap storage, position table and result register
// Executes one controller operation per cycle and reports status flags.
// ----------------------------------------------------------------------------
module mhtq_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mhtq_pkg::dp_cmd_t                 ctl,
    output mhtq_pkg::dp_status_t              sts,
    input  logic [1:0]                        cmd,
    input  logic [mhtq_pkg::ID_W-1:0]         timer_id,
    input  logic [mhtq_pkg::TIMEOUT_W-1:0]    timeout_ms,
    input  logic [mhtq_pkg::TIME_W-1:0]       now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mhtq_pkg::ID_W-1:0]         expired_id,
    output logic                              fired,
    output logic [1:0]                        status,
    output logic [mhtq_pkg::WAIT_W-1:0]       next_wait_ms,
    output logic                              queue_empty,
    output logic                              last
);
    import mhtq_pkg::*;

    // Heap and position memories.
    logic [TIME_W-1:0] heap_exp_mem [CAPACITY];
    logic [ID_W-1:0]   heap_id_mem  [CAPACITY];
    logic [IDX_W-1:0]  pos_mem      [ID_LIMIT];

    // Request and work registers.
    cmd_t               cmd_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   c_reg, c_next;
    logic [TIME_W-1:0]  e_reg, e_next;
    logic [ID_W-1:0]    mid_reg, mid_next;
    logic [TIME_W-1:0]  b_exp_reg, b_exp_next;
    logic [ID_W-1:0]    b_id_reg, b_id_next;
    logic [TIME_W-1:0]  rd_exp_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [IDX_W-1:0]   pos_rd_reg;

    // Result register.
    logic               out_valid_reg;
    logic [ID_W-1:0]    expired_id_reg;
    logic               fired_reg;
    status_t            status_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               qe_reg;
    logic               last_reg;

    // Memory port controls.
    logic               hr_en;
    logic [IDX_W-1:0]   hr_addr;
    logic               hw_en;
    logic [IDX_W-1:0]   hw_addr;
    logic [TIME_W-1:0]  hw_exp;
    logic [ID_W-1:0]    hw_id;
    logic               pr_en;
    logic               pw_en;
    logic [ID_W-1:0]    pw_addr;
    logic [IDX_W-1:0]   pw_data;

    // Heap index arithmetic.
    logic [IDX_W-1:0]   parent_idx;
    logic [CHILD_W-1:0] left_w;
    logic [CHILD_W-1:0] right_w;
    logic [TIME_W-1:0]  root_diff;
    logic [WAIT_W-1:0]  wait_val;
    logic               qe_val;

    assign parent_idx = (i_reg - IDX_W'(1)) >> 1;
    assign left_w     = {1'b0, i_reg, 1'b1};
    assign right_w    = left_w + CHILD_W'(1);
    assign root_diff  = rd_exp_reg - now_reg;

    // Status flags for the controller.
    always_comb
    begin
        sts.cmd           = cmd_reg;
        sts.known         = (CNT_W'(pos_rd_reg) < count_reg) && (rd_id_reg == req_id_reg);
        sts.full          = count_reg == CNT_W'(CAPACITY);
        sts.count_zero    = count_reg == '0;
        sts.i_zero        = i_reg == '0;
        sts.i_is_last     = CNT_W'(i_reg) == count_reg - CNT_W'(1);
        sts.has_left      = left_w < CHILD_W'(count_reg);
        sts.has_right     = right_w < CHILD_W'(count_reg);
        sts.up_earlier    = earlier(e_reg, rd_exp_reg);
        sts.right_earlier = earlier(rd_exp_reg, b_exp_reg);
        sts.down_earlier  = earlier(b_exp_reg, e_reg);
        sts.root_expired  = (root_diff == '0) || root_diff[TIME_W-1];
        sts.out_free      = !out_valid_reg || out_ready;
    end

    // Memory port selection per operation.
    always_comb
    begin
        hr_en   = 1'b0;
        hr_addr = '0;
        hw_en   = 1'b0;
        hw_addr = i_reg;
        hw_exp  = e_reg;
        hw_id   = mid_reg;
        pr_en   = 1'b0;
        pw_en   = 1'b0;
        pw_addr = mid_reg;
        pw_data = i_reg;
        unique case (ctl.op)
            OP_POS_READ:  pr_en = 1'b1;
            OP_SLOT_READ:
            begin
                hr_en   = 1'b1;
                hr_addr = pos_rd_reg;
            end
            OP_TICK_READ: hr_en = 1'b1;
            OP_REMOVE:
            begin
                hr_en   = 1'b1;
                hr_addr = IDX_W'(count_reg - CNT_W'(1));
            end
            OP_UP_READ:
            begin
                hr_en   = 1'b1;
                hr_addr = parent_idx;
            end
            OP_UP_MOVE:
            begin
                hw_en   = 1'b1;
                hw_exp  = rd_exp_reg;
                hw_id   = rd_id_reg;
                pw_en   = 1'b1;
                pw_addr = rd_id_reg;
            end
            OP_DN_READ_L:
            begin
                hr_en   = 1'b1;
                hr_addr = left_w[IDX_W-1:0];
            end
            OP_DN_LATCH_L:
            begin
                hr_en   = sts.has_right;
                hr_addr = right_w[IDX_W-1:0];
            end
            OP_DN_MOVE:
            begin
                hw_en   = 1'b1;
                hw_exp  = b_exp_reg;
                hw_id   = b_id_reg;
                pw_en   = 1'b1;
                pw_addr = b_id_reg;
            end
            OP_PLACE:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
            end
            default: ;
        endcase
    end

    // Heap and position memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_exp_mem[hw_addr] <= hw_exp;
            heap_id_mem[hw_addr]  <= hw_id;
        end
        if (hr_en)
        begin
            rd_exp_reg <= heap_exp_mem[hr_addr];
            rd_id_reg  <= heap_id_mem[hr_addr];
        end
        if (pw_en)
            pos_mem[pw_addr] <= pw_data;
        if (pr_en)
            pos_rd_reg <= pos_mem[req_id_reg];
    end

    // Next values of the work registers.
    always_comb
    begin
        count_next = count_reg;
        i_next     = i_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        mid_next   = mid_reg;
        b_exp_next = b_exp_reg;
        b_id_next  = b_id_reg;
        unique case (ctl.op)
            OP_SLOT_READ: i_next = pos_rd_reg;
            OP_CLEAR:     count_next = '0;
            OP_ADD_KNOWN:
            begin
                e_next   = now_reg + TIME_W'(timeout_reg);
                mid_next = req_id_reg;
            end
            OP_ADD_NEW:
            begin
                e_next     = now_reg + TIME_W'(timeout_reg);
                mid_next   = req_id_reg;
                i_next     = IDX_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
            end
            OP_TICK_READ: i_next = '0;
            OP_REMOVE:    count_next = count_reg - CNT_W'(1);
            OP_LOAD_LAST:
            begin
                e_next   = rd_exp_reg;
                mid_next = rd_id_reg;
            end
            OP_UP_MOVE:   i_next = parent_idx;
            OP_DN_LATCH_L:
            begin
                b_exp_next = rd_exp_reg;
                b_id_next  = rd_id_reg;
                c_next     = left_w[IDX_W-1:0];
            end
            OP_DN_PICK_R:
            begin
                if (sts.right_earlier)
                begin
                    b_exp_next = rd_exp_reg;
                    b_id_next  = rd_id_reg;
                    c_next     = c_reg + IDX_W'(1);
                end
            end
            OP_DN_MOVE:   i_next = c_reg;
            default: ;
        endcase
    end

    // Result field values.
    always_comb
    begin
        if (count_reg == '0)
            wait_val = WAIT_MAX;
        else if (root_diff > TIME_W'(WAIT_MAX))
            wait_val = WAIT_MAX;
        else
            wait_val = root_diff[WAIT_W-1:0];
        unique case (ctl.emit.qe)
            QE_NOW:  qe_val = count_reg == '0;
            QE_ONE:  qe_val = count_reg == CNT_W'(1);
            default: qe_val = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.emit.en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
        begin
            cmd_reg     <= cmd_t'(cmd);
            req_id_reg  <= timer_id;
            timeout_reg <= timeout_ms;
            now_reg     <= now_ms;
        end
        i_reg     <= i_next;
        c_reg     <= c_next;
        e_reg     <= e_next;
        mid_reg   <= mid_next;
        b_exp_reg <= b_exp_next;
        b_id_reg  <= b_id_next;
        if (ctl.emit.en)
        begin
            expired_id_reg <= ctl.emit.fired ? rd_id_reg : '0;
            fired_reg      <= ctl.emit.fired;
            status_reg     <= ctl.emit.status;
            wait_reg       <= ctl.emit.with_wait ? wait_val : '0;
            qe_reg         <= qe_val;
            last_reg       <= ctl.emit.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign expired_id   = expired_id_reg;
    assign fired        = fired_reg;
    assign status       = status_reg;
    assign next_wait_ms = wait_reg;
    assign queue_empty  = qe_reg;
    assign last         = last_reg;

endmodule

### rtl/mhtq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_ctrl: command sequencer of the timeout queue
// Walks lookup, result emission, removal and heap sifts one step a cycle, or stalls.
// ----------------------------------------------------------------------------
module mhtq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mhtq_pkg::dp_status_t sts,
    output mhtq_pkg::dp_cmd_t    ctl
);
    import mhtq_pkg::*;

    state_t state_reg, state_next;
    logic   skip_dn_reg, skip_dn_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            skip_dn_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            skip_dn_reg <= skip_dn_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next         = state_reg;
        skip_dn_next       = skip_dn_reg;
        ctl.op             = OP_NONE;
        ctl.emit.en        = 1'b0;
        ctl.emit.fired     = 1'b0;
        ctl.emit.status    = STATUS_OK;
        ctl.emit.with_wait = 1'b0;
        ctl.emit.qe        = QE_NOW;
        ctl.emit.last      = 1'b1;
        in_ready           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op       = OP_LOAD;
                    skip_dn_next = 1'b0;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_CLEAR: state_next = ST_CLEAR;
                    CMD_TICK:  state_next = ST_TICK;
                    default:
                    begin
                        ctl.op     = OP_POS_READ;
                        state_next = ST_SLOT_RD;
                    end
                endcase
            end
            ST_SLOT_RD:
            begin
                ctl.op     = OP_SLOT_READ;
                state_next = ST_DECIDE;
            end
            // The result goes out before the heap work it describes.
            ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit.en = 1'b1;
                    if (sts.cmd == CMD_ADD)
                    begin
                        ctl.emit.qe = QE_ZERO;
                        if (sts.known)
                        begin
                            ctl.op     = OP_ADD_KNOWN;
                            state_next = ST_UP;
                        end
                        else if (sts.full)
                        begin
                            ctl.emit.status = STATUS_FULL;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            // A new entry only moves up.
                            ctl.op       = OP_ADD_NEW;
                            skip_dn_next = 1'b1;
                            state_next   = ST_UP;
                        end
                    end
                    else if (sts.known)
                    begin
                        ctl.emit.fired = 1'b1;
                        ctl.emit.qe    = QE_ONE;
                        state_next     = ST_REMOVE;
                    end
                    else
                    begin
                        ctl.emit.status = STATUS_UNKNOWN;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                ctl.op     = OP_CLEAR;
                state_next = ST_EMIT_CLEAR;
            end
            ST_EMIT_CLEAR:
            begin
                if (sts.out_free)
                begin
                    ctl.emit.en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (sts.count_zero)
                begin
                    if (sts.out_free)
                    begin
                        ctl.emit.en        = 1'b1;
                        ctl.emit.with_wait = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
                else
                begin
                    ctl.op     = OP_TICK_READ;
                    state_next = ST_TICK_CMP;
                end
            end
            ST_TICK_CMP:
            begin
                if (sts.out_free)
                begin
                    ctl.emit.en = 1'b1;
                    if (sts.root_expired)
                    begin
                        ctl.emit.fired = 1'b1;
                        ctl.emit.qe    = QE_ONE;
                        ctl.emit.last  = 1'b0;
                        state_next     = ST_REMOVE;
                    end
                    else
                    begin
                        ctl.emit.with_wait = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
            end
            // Drop the slot; the last entry refills it unless it was the last.
            ST_REMOVE:
            begin
                ctl.op = OP_REMOVE;
                if (!sts.i_is_last)
                    state_next = ST_REMOVE_LOAD;
                else if (sts.cmd == CMD_TICK)
                    state_next = ST_TICK;
                else
                    state_next = ST_IDLE;
            end
            ST_REMOVE_LOAD:
            begin
                ctl.op     = OP_LOAD_LAST;
                state_next = ST_UP;
            end
            // Sift up: move parents down into the hole while the entry is earlier.
            ST_UP:
            begin
                if (sts.i_zero)
                    state_next = skip_dn_reg ? ST_PLACE : ST_DN;
                else
                begin
                    ctl.op     = OP_UP_READ;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (sts.up_earlier)
                begin
                    ctl.op     = OP_UP_MOVE;
                    state_next = ST_UP;
                end
                else
                    state_next = skip_dn_reg ? ST_PLACE : ST_DN;
            end
            // Sift down: pull the earlier child up while it beats the entry.
            ST_DN:
            begin
                if (sts.has_left)
                begin
                    ctl.op     = OP_DN_READ_L;
                    state_next = ST_DN_L;
                end
                else
                    state_next = ST_PLACE;
            end
            ST_DN_L:
            begin
                ctl.op     = OP_DN_LATCH_L;
                state_next = sts.has_right ? ST_DN_R : ST_DN_CMP;
            end
            ST_DN_R:
            begin
                ctl.op     = OP_DN_PICK_R;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (sts.down_earlier)
                begin
                    ctl.op     = OP_DN_MOVE;
                    state_next = ST_DN;
                end
                else
                    state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                ctl.op     = OP_PLACE;
                state_next = (sts.cmd == CMD_TICK) ? ST_TICK : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/mhtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_checker: port-level checks of the timeout queue
// Watches the request and result channels and flags broken result rules.
// ----------------------------------------------------------------------------
module mhtq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [mhtq_pkg::ID_W-1:0]         expired_id,
    input logic                              fired,
    input logic [1:0]                        status,
    input logic [mhtq_pkg::WAIT_W-1:0]       next_wait_ms,
    input logic                              last
);
    import mhtq_pkg::*;

    // A request keeps the block busy in the following cycle.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous request still busy");

    // A stalled result holds its id and last flag.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(expired_id) && $stable(last))
        else $error("stalled result changed");

    // Only fired results may be non-final.
    a_nonfinal_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> fired && status == STATUS_OK)
        else $error("non-final result without fired timer");

    // A result without a fired timer carries id zero.
    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> expired_id == '0)
        else $error("expired id set on a result without fired timer");

    // The wait figure appears only on final results without a fired timer.
    a_wait_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_wait_ms != '0 |-> last && !fired)
        else $error("wait reported on a non-final result");

endmodule

bind min_heap_timeout_queue mhtq_checker u_chk (.*);
